### rtl/icmp_er_pkg.sv
package icmp_er_pkg;

  // Largest number of bytes of one packet that are processed.
  localparam logic [15:0] MaxPacketLen = 16'hFFFF;
  // Smallest legal IPv4 header, in bytes.
  localparam logic [5:0]  MinHeaderBytes = 6'd20;
  localparam logic [7:0]  EchoRequestType = 8'd8;
  localparam logic [15:0] SumGood = 16'hFFFF;

  // Byte offsets within the IPv4 header.
  localparam logic [15:0] PosVersion  = 16'd0;
  localparam logic [15:0] PosLenHigh  = 16'd2;
  localparam logic [15:0] PosLenLow   = 16'd3;
  localparam logic [15:0] PosSrcFirst = 16'd12;
  localparam logic [15:0] PosSrcLast  = 16'd15;
  localparam logic [15:0] PosDstFirst = 16'd16;
  localparam logic [15:0] PosDstLast  = 16'd19;

  // Word offsets within the ICMP message.
  localparam logic [15:0] OffTypeWord  = 16'd0;
  localparam logic [15:0] OffCsumWord  = 16'd2;

  typedef enum logic [1:0] {
    ActReply   = 2'd0,
    ActBadCsum = 2'd1,
    ActNotEcho = 2'd2,
    ActNotOurs = 2'd3
  } action_e;

  // Per-packet state, also used as the snapshot handed to the verdict logic.
  typedef struct packed {
    logic [15:0] byte_pos;
    logic [5:0]  hdr_bytes;
    logic [15:0] total_len;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] verify_sum;
    logic [15:0] reply_sum;
    logic [7:0]  msg_type;
    logic [7:0]  held_byte;
    logic        overflow;
  } pkt_snap_t;

  typedef struct packed {
    logic [5:0]  header_length;
    logic [15:0] icmp_length;
    logic [31:0] reply_dest_ip;
    logic [31:0] reply_source_ip;
    logic [15:0] reply_checksum;
    action_e     action;
  } verdict_t;

  function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

### rtl/icmp_er_parser.sv
module icmp_er_parser
  import icmp_er_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_vld_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output pkt_snap_t  snap_o
);

  pkt_snap_t   st_q;
  pkt_snap_t   st_d;
  logic [15:0] pos;
  logic [15:0] off;
  logic [15:0] word;
  logic [15:0] rword;
  logic [15:0] woff;
  logic        in_icmp;
  logic        ends_here;

  assign pos  = st_q.byte_pos;
  assign woff = {off[15:1], 1'b0};

  always_comb begin
    st_d      = st_q;
    off       = '0;
    in_icmp   = 1'b0;
    ends_here = 1'b0;
    word      = '0;
    rword     = '0;
    if (pos >= MaxPacketLen) begin
      st_d.overflow = 1'b1;
    end else begin
      if (pos == PosVersion) begin
        st_d.hdr_bytes = {byte_i[3:0], 2'b00};
      end else if (pos == PosLenHigh) begin
        st_d.total_len = {byte_i, st_q.total_len[7:0]};
      end else if (pos == PosLenLow) begin
        st_d.total_len = {st_q.total_len[15:8], byte_i};
      end else if (pos >= PosSrcFirst && pos <= PosSrcLast) begin
        st_d.src_ip = {st_q.src_ip[23:0], byte_i};
      end else if (pos >= PosDstFirst && pos <= PosDstLast) begin
        st_d.dst_ip = {st_q.dst_ip[23:0], byte_i};
      end

      in_icmp = (st_d.hdr_bytes >= MinHeaderBytes) &&
                (pos >= {10'd0, st_d.hdr_bytes}) && (pos < st_d.total_len);
      off       = pos - {10'd0, st_d.hdr_bytes};
      ends_here = ({1'b0, pos} + 17'd1) == {1'b0, st_d.total_len};
      word      = off[0] ? {st_q.held_byte, byte_i} : {byte_i, 8'h00};

      if (woff == OffTypeWord) begin
        rword = {8'h00, word[7:0]};
      end else if (woff == OffCsumWord) begin
        rword = '0;
      end else begin
        rword = word;
      end

      if (in_icmp) begin
        if (off == OffTypeWord) begin
          st_d.msg_type = byte_i;
        end
        if (off[0] || ends_here) begin
          st_d.verify_sum = ones_add(st_q.verify_sum, word);
          st_d.reply_sum  = ones_add(st_q.reply_sum, rword);
        end else begin
          st_d.held_byte = byte_i;
        end
      end
      st_d.byte_pos = pos + 16'd1;
    end
  end

  // The verdict is taken from the state as it stands after the last byte.
  assign snap_o = st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (byte_vld_i) begin
      if (last_i) begin
        st_q <= '0;
      end else begin
        st_q <= st_d;
      end
    end
  end

endmodule

### rtl/icmp_er_verdict.sv
module icmp_er_verdict
  import icmp_er_pkg::*;
(
  input  pkt_snap_t   snap_i,
  input  logic [31:0] own_ip_i,
  output verdict_t    verdict_o
);

  logic        short_total;
  logic        bad;
  logic [15:0] hdr_wide;

  assign hdr_wide    = {10'd0, snap_i.hdr_bytes};
  assign short_total = snap_i.total_len < hdr_wide;

  assign bad = snap_i.overflow ||
               (snap_i.hdr_bytes < MinHeaderBytes) ||
               (snap_i.byte_pos < {10'd0, MinHeaderBytes}) ||
               short_total ||
               (snap_i.byte_pos < snap_i.total_len) ||
               (snap_i.verify_sum != SumGood);

  always_comb begin
    verdict_o.header_length   = snap_i.hdr_bytes;
    verdict_o.icmp_length     = short_total ? 16'd0 : snap_i.total_len - hdr_wide;
    verdict_o.reply_source_ip = snap_i.dst_ip;
    verdict_o.reply_dest_ip   = snap_i.src_ip;
    verdict_o.reply_checksum  = ~snap_i.reply_sum;
    if (bad) begin
      verdict_o.action         = ActBadCsum;
      verdict_o.reply_checksum = '0;
    end else if (snap_i.msg_type != EchoRequestType) begin
      verdict_o.action         = ActNotEcho;
      verdict_o.reply_checksum = '0;
    end else if (snap_i.dst_ip != own_ip_i) begin
      verdict_o.action = ActNotOurs;
    end else begin
      verdict_o.action = ActReply;
    end
  end

endmodule

### rtl/icmp_echo_responder.sv
// ICMP echo request verdict engine for IPv4.
// The packet enters on the slave stream one byte per beat, starting at the
// version byte, with tlast on its final byte. Nothing comes out until that
// final beat; then exactly one verdict beat leaves on the master stream,
// carrying the action, the echo-reply checksum, the swapped addresses, the
// ICMP length and the IP header length.
// Throughput is one byte per clock cycle unless a held last beat stalls it:
// each beat passes an input register and then a single stage that updates
// the header fields and the two ones'-complement sums, so consecutive beats
// may arrive in every cycle. The verdict is registered: the last byte waits
// in the input register, and the verdict is captured in the result register
// as that byte moves on.
// When the receiver stalls, the verdict waits in the result register and
// bytes of the next packet keep flowing; only the next last beat is held in
// the input register, and tready falls, until the verdict has been taken.
// Reset clears the per-packet state, both valid flags and own_ip_address.
// own_ip_address sits at byte address 0 of the APB-style port; it is to be
// written only while no packet is in flight.
module icmp_echo_responder
  import icmp_er_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // Slave stream: tdata = packet_byte[7:0]; tlast = last_byte.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tlast,
  // Master stream, tdata from the lowest bit: action[1:0],
  // reply_checksum[17:2], reply_source_ip[49:18], reply_dest_ip[81:50],
  // icmp_length[97:82], header_length[103:98].
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [31:0] own_ip_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        out_valid_q;
  verdict_t    out_q;
  logic        adv;
  pkt_snap_t   snap;
  verdict_t    verdict;

  // With a single register every address decodes to own_ip_address.
  assign pready = 1'b1;
  assign prdata = own_ip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[1:0] == 2'd0 || 1'b1)) begin
      own_ip_q <= pwdata;
    end
  end

  // A byte moves on unless it is a last byte and the result register is
  // still occupied by a verdict that is not being taken.
  assign adv           = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  icmp_er_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_vld_i (adv),
    .byte_i     (in_byte_q),
    .last_i     (in_last_q),
    .snap_o     (snap)
  );

  icmp_er_verdict u_verdict (
    .snap_i    (snap),
    .own_ip_i  (own_ip_q),
    .verdict_o (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) begin
      out_q <= verdict;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  // A last byte that moves on always leaves a verdict behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_last_q) |=> m_axis_tvalid)
    else $error("verdict missing after last byte");

  // A byte that is not last never produces or removes a verdict by itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(adv && in_last_q) && !(m_axis_tvalid && m_axis_tready))
      |=> $stable(m_axis_tvalid))
    else $error("verdict appeared or vanished without cause");

  // A held byte is never lost from the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !adv) |=> in_valid_q)
    else $error("stalled byte dropped");

  // Rejected packets carry no checksum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_q.action == ActBadCsum || out_q.action == ActNotEcho))
      |-> (out_q.reply_checksum == 16'd0))
    else $error("checksum on rejected packet");
`endif

endmodule

### verif/icmp_echo_responder_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the ICMP echo verdict engine. IPv4 packets are
// streamed in one byte per beat from a queue of pending beats. A monitor
// follows every accepted byte with its own model of the engine and lines up
// one expected verdict per packet. Each verdict beat that leaves the block is
// compared field by field with the oldest one waiting. The sender works in
// bursts and the receiver stalls in changing patterns. The own-address
// register is rewritten between phases, only while the engine is idle.
module icmp_echo_responder_test;
  import icmp_er_pkg::*;

  localparam int unsigned CycleLimit   = 4_000_000;
  localparam int          ResetCycles  = 6;
  // Margin that wait_idle adds once every verdict is back.
  localparam int          SettleCycles = 4;
  localparam int          MaxReports   = 40;
  localparam logic [1:0]  OwnIpAddr    = 2'd0;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef enum logic [1:0] {
    ReadyAlways,
    ReadyCoin,
    ReadySparse,
    ReadyPeriodic
  } ready_mode_e;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b1;
  logic [103:0] m_axis_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [1:0]   paddr = 2'd0;
  logic [31:0]  pwdata = 32'h0;
  logic [31:0]  prdata;
  logic         pready;

  icmp_echo_responder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Stimulus side.
  logic [7:0]  pkt_bytes[$];
  beat_t       pending_beats[$];
  logic [31:0] own_ip_now = 32'h0;
  int          burst_left = 0;
  int          gap_left = 0;

  // Checking side: the engine's state as the monitor sees it.
  verdict_t    awaited_verdicts[$];
  logic [31:0] own_ip_seen = 32'h0;
  int unsigned pkt_pos = 0;
  logic [5:0]  hdr_bytes = '0;
  logic [15:0] total_len = '0;
  logic [31:0] src_ip = '0;
  logic [31:0] dst_ip = '0;
  logic [15:0] check_sum = '0;
  logic [15:0] echo_sum = '0;
  logic [7:0]  msg_kind = '0;
  logic [7:0]  pending_high = '0;
  logic        len_overflow = 1'b0;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  ready_mode_e ready_mode = ReadyAlways;
  int          ready_window = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Ones'-complement addition with the end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] x, input logic [15:0] y);
    int unsigned t;
    t = x + y;
    return t[15:0] + t[31:16];
  endfunction

  // Sum of a stretch of the packet being built, as 16-bit big-endian words
  // with an odd final byte padded by a zero low byte.
  function automatic logic [15:0] message_sum(input int start, input int len);
    logic [15:0] acc;
    int          k;
    acc = 16'h0;
    for (k = 0; k < len; k += 2) begin
      acc = oc_add(acc, {pkt_bytes[start + k],
                         (k + 1 < len) ? pkt_bytes[start + k + 1] : 8'h00});
    end
    return acc;
  endfunction

  // Adds one 16-bit word to both running sums. In the echo-reply sum the
  // type byte counts as zero and the checksum word is left out entirely.
  task automatic add_icmp_word(input logic [15:0] word, input int unsigned word_off);
    check_sum = oc_add(check_sum, word);
    if (word_off == OffTypeWord) begin
      echo_sum = oc_add(echo_sum, {8'h00, word[7:0]});
    end else if (word_off != OffCsumWord) begin
      echo_sum = oc_add(echo_sum, word);
    end
  endtask

  // Follows one accepted byte; on the last byte of a packet it works out the
  // verdict the engine has to give and clears the per-packet state.
  task automatic take_packet_byte(input logic [7:0] b, input logic is_last);
    int unsigned off;
    verdict_t    v;
    if (pkt_pos >= MaxPacketLen) begin
      // The count saturates and the rest of an oversized packet is dropped.
      len_overflow = 1'b1;
    end else begin
      if (pkt_pos == PosVersion) begin
        hdr_bytes = {b[3:0], 2'b00};
      end else if (pkt_pos == PosLenHigh) begin
        total_len[15:8] = b;
      end else if (pkt_pos == PosLenLow) begin
        total_len[7:0] = b;
      end else if (pkt_pos >= PosSrcFirst && pkt_pos <= PosSrcLast) begin
        src_ip = {src_ip[23:0], b};
      end else if (pkt_pos >= PosDstFirst && pkt_pos <= PosDstLast) begin
        dst_ip = {dst_ip[23:0], b};
      end
      // Only bytes of the ICMP message, inside the total length, are summed.
      if (hdr_bytes >= MinHeaderBytes && pkt_pos >= hdr_bytes && pkt_pos < total_len) begin
        off = pkt_pos - hdr_bytes;
        if (off == 0) begin
          msg_kind = b;
        end
        if (!off[0]) begin
          if (pkt_pos + 1 == total_len) begin
            add_icmp_word({b, 8'h00}, off);
          end else begin
            pending_high = b;
          end
        end else begin
          add_icmp_word({pending_high, b}, off - 1);
        end
      end
      pkt_pos++;
    end

    if (is_last) begin
      v.header_length   = hdr_bytes;
      v.icmp_length     = (total_len >= hdr_bytes) ? total_len - hdr_bytes : 16'd0;
      v.reply_source_ip = dst_ip;
      v.reply_dest_ip   = src_ip;
      v.reply_checksum  = ~echo_sum;
      if (len_overflow || hdr_bytes < MinHeaderBytes || pkt_pos < MinHeaderBytes ||
          total_len < hdr_bytes || pkt_pos < total_len || check_sum != SumGood) begin
        v.action         = ActBadCsum;
        v.reply_checksum = 16'h0;
      end else if (msg_kind != EchoRequestType) begin
        v.action         = ActNotEcho;
        v.reply_checksum = 16'h0;
      end else if (dst_ip != own_ip_seen) begin
        v.action = ActNotOurs;
      end else begin
        v.action = ActReply;
      end
      awaited_verdicts.push_back(v);
      pkt_pos      = 0;
      hdr_bytes    = '0;
      total_len    = '0;
      src_ip       = '0;
      dst_ip       = '0;
      check_sum    = '0;
      echo_sum     = '0;
      msg_kind     = '0;
      pending_high = '0;
      len_overflow = 1'b0;
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MaxReports) begin
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
    end
  endtask

  // Builds an IPv4 packet with an ICMP message of msg_len bytes. With a legal
  // header, msg_len >= 4 gets a right checksum; a clear sum_ok spoils one bit.
  // A header shorter than 20 bytes still gets the full address fields.
  task automatic make_echo(input int hdr_words, input int msg_len,
                           input logic [7:0] msg_type, input logic [31:0] dst,
                           input bit sum_ok);
    int          hdr;
    int          tot;
    int          n;
    int          k;
    int          idx;
    logic [15:0] csum;
    hdr = hdr_words * 4;
    tot = hdr + msg_len;
    n   = ((hdr < MinHeaderBytes) ? int'(MinHeaderBytes) : hdr) + msg_len;
    pkt_bytes.delete();
    for (k = 0; k < n; k++) begin
      pkt_bytes.push_back(8'($urandom()));
    end
    pkt_bytes[0] = {4'h4, 4'(hdr_words)};
    pkt_bytes[2] = 8'(tot >> 8);
    pkt_bytes[3] = 8'(tot);
    for (k = 0; k < 4; k++) begin
      pkt_bytes[16 + k] = dst[31 - 8 * k -: 8];
    end
    if (hdr >= MinHeaderBytes && msg_len > 0) begin
      pkt_bytes[hdr] = msg_type;
      if (msg_len >= 4) begin
        pkt_bytes[hdr + 2] = 8'h00;
        pkt_bytes[hdr + 3] = 8'h00;
        csum = ~message_sum(hdr, msg_len);
        pkt_bytes[hdr + 2] = csum[15:8];
        pkt_bytes[hdr + 3] = csum[7:0];
      end
      if (!sum_ok) begin
        idx = hdr + $urandom_range(0, msg_len - 1);
        pkt_bytes[idx] = pkt_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
      end
    end
  endtask

  task automatic fill_bytes(input int n, input logic [7:0] value);
    pkt_bytes.delete();
    repeat (n) pkt_bytes.push_back(value);
  endtask

  task automatic send_packet();
    int k;
    for (k = 0; k < pkt_bytes.size(); k++) begin
      pending_beats.push_back({pkt_bytes[k], k == pkt_bytes.size() - 1});
    end
  endtask

  // Mostly well-formed echo requests with random content; the remainder is
  // other message types, damaged packets and plain noise.
  task automatic random_phase(input int byte_goal, input int packet_goal);
    int          bytes_done;
    int          packets_done;
    int          pick;
    int          hw;
    int          ml;
    logic [31:0] dst;
    bytes_done   = 0;
    packets_done = 0;
    while (bytes_done < byte_goal || packets_done < packet_goal) begin
      pick = $urandom_range(0, 99);
      hw   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
      ml   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 32);
      dst  = ($urandom_range(0, 4) == 0) ? $urandom() : own_ip_now;
      if (pick < 60) begin
        make_echo(hw, ml, EchoRequestType, dst, $urandom_range(0, 9) != 0);
      end else if (pick < 70) begin
        make_echo(hw, ml, ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom()), dst, 1'b1);
      end else if (pick < 80) begin
        make_echo($urandom_range(0, 15), ml, EchoRequestType, dst, 1'b1);
        case ($urandom_range(0, 1))
          0: begin
            repeat ($urandom_range(1, pkt_bytes.size() - 1)) void'(pkt_bytes.pop_back());
          end
          default: begin
            pkt_bytes[2] = 8'($urandom_range(0, 1) ? $urandom() : 0);
            pkt_bytes[3] = 8'($urandom());
          end
        endcase
      end else begin
        pkt_bytes.delete();
        repeat ($urandom_range(1, 48)) pkt_bytes.push_back(8'($urandom()));
      end
      // Padding after the total length must be ignored by the engine.
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) pkt_bytes.push_back(8'($urandom()));
      end
      // The version nibble plays no part in the verdict.
      if ($urandom_range(0, 4) == 0) begin
        pkt_bytes[0] = {4'($urandom()), pkt_bytes[0][3:0]};
      end
      bytes_done += pkt_bytes.size();
      packets_done++;
      send_packet();
    end
  endtask

  // Returns on a falling edge once every queued byte has gone in and every
  // verdict has come out, plus a margin for the pipeline.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || s_axis_tvalid || awaited_verdicts.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Setup beat, then access beat; the register takes the value at the edge
  // where the access phase meets pready.
  task automatic write_own_ip(input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= OwnIpAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    own_ip_now = value;
    @(negedge clk_i);
  endtask

  // Sender: one beat from the queue per cycle while in a burst, random gaps
  // between bursts, and a beat on the bus is held until it is taken.
  always @(posedge clk_i) begin : drive_bytes
    beat_t next_beat;
    if (rst_ni && !(s_axis_tvalid && !s_axis_tready)) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        next_beat = pending_beats.pop_front();
        s_axis_tdata  <= next_beat.data;
        s_axis_tlast  <= next_beat.last;
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: the stall pattern is redrawn whenever its random window runs out.
  always @(posedge clk_i) begin
    if (ready_window == 0) begin
      ready_mode   <= ready_mode_e'($urandom_range(0, 3));
      ready_window <= $urandom_range(20, 200);
    end else begin
      ready_window <= ready_window - 1;
    end
    case (ready_mode)
      ReadyAlways: m_axis_tready <= 1'b1;
      ReadyCoin:   m_axis_tready <= 1'($urandom_range(0, 1));
      ReadySparse: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:     m_axis_tready <= (cycle_count[3:0] >= 4'd10);
    endcase
  end

  // Monitor: register writes, accepted bytes and accepted verdicts.
  always @(posedge clk_i) begin : watch_ports
    verdict_t seen;
    verdict_t want;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready && paddr == OwnIpAddr) begin
        own_ip_seen = pwdata;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        take_packet_byte(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen = verdict_t'(m_axis_tdata);
        if (awaited_verdicts.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("%0t ns: unexpected verdict beat, expected none, got %h",
                     $time, m_axis_tdata);
          end
        end else begin
          want = awaited_verdicts.pop_front();
          check_field("action", want.action, seen.action);
          check_field("reply_checksum", want.reply_checksum, seen.reply_checksum);
          check_field("reply_source_ip", want.reply_source_ip, seen.reply_source_ip);
          check_field("reply_dest_ip", want.reply_dest_ip, seen.reply_dest_ip);
          check_field("icmp_length", want.icmp_length, seen.icmp_length);
          check_field("header_length", want.header_length, seen.header_length);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("icmp_echo_responder_test: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed packets, with the own address at zero.
    write_own_ip(32'h0000_0000);
    // Shortest echo request for us, then an odd length and a full header.
    make_echo(5, 8, EchoRequestType, 32'h0, 1'b1);
    send_packet();
    make_echo(5, 9, EchoRequestType, 32'h0, 1'b1);
    send_packet();
    make_echo(15, 13, EchoRequestType, 32'h0, 1'b1);
    send_packet();
    // An empty ICMP message can never verify.
    make_echo(5, 0, EchoRequestType, 32'h0, 1'b1);
    send_packet();
    // Total length below the header length.
    make_echo(5, 8, EchoRequestType, 32'h0, 1'b1);
    pkt_bytes[2] = 8'h00;
    pkt_bytes[3] = 8'd12;
    send_packet();
    // Malformed header lengths.
    make_echo(4, 8, EchoRequestType, 32'h0, 1'b1);
    send_packet();
    make_echo(0, 8, EchoRequestType, 32'h0, 1'b1);
    send_packet();
    // A lone byte, and a packet cut off inside the address fields.
    fill_bytes(1, 8'h45);
    send_packet();
    make_echo(5, 8, EchoRequestType, 32'h0, 1'b1);
    repeat (9) void'(pkt_bytes.pop_back());
    send_packet();
    // Fewer bytes than the total length promises.
    make_echo(5, 16, EchoRequestType, 32'h0, 1'b1);
    repeat (3) void'(pkt_bytes.pop_back());
    send_packet();
    // Trailing bytes past the total length.
    make_echo(5, 8, EchoRequestType, 32'h0, 1'b1);
    repeat (5) pkt_bytes.push_back(8'($urandom()));
    send_packet();
    // Other message types, a foreign destination and a corrupt checksum.
    make_echo(5, 8, 8'h00, 32'h0, 1'b1);
    send_packet();
    make_echo(5, 10, 8'hFF, 32'h0, 1'b1);
    send_packet();
    make_echo(5, 8, EchoRequestType, 32'hFFFF_FFFF, 1'b1);
    send_packet();
    make_echo(5, 8, EchoRequestType, 32'h0, 1'b0);
    send_packet();
    // Priority: checksum before type, type before address.
    make_echo(5, 8, 8'h00, 32'h0000_0001, 1'b0);
    send_packet();
    make_echo(5, 8, 8'h0D, 32'h0000_0001, 1'b1);
    send_packet();
    // Extreme byte values throughout.
    fill_bytes(30, 8'h00);
    send_packet();
    fill_bytes(30, 8'hFF);
    send_packet();
    // The longest packet that is processed in full, then one that overruns.
    make_echo(5, 65515, EchoRequestType, 32'h0, 1'b1);
    send_packet();
    make_echo(5, 65515, EchoRequestType, 32'h0, 1'b1);
    repeat (5) pkt_bytes.push_back(8'($urandom()));
    send_packet();
    wait_idle();

    // Random traffic under several addresses. The sender also holds off
    // half-way through one setting until every verdict is back.
    write_own_ip(32'hFFFF_FFFF);
    random_phase(350, 16);
    wait_idle();
    write_own_ip($urandom());
    random_phase(180, 8);
    wait_idle();
    random_phase(180, 8);
    wait_idle();
    write_own_ip($urandom());
    random_phase(350, 16);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("icmp_echo_responder_test: done, clean");
    end else begin
      $display("icmp_echo_responder_test: done, errors");
    end
    $finish;
  end

endmodule
